### src/scmc_pkg.sv
// Package for the SCCB master controller: widths, reset values, codes and
// the classified item type shared by the front end, queue and bus engine.
// No dependencies.
`default_nettype none

package scmc_pkg;

  localparam int unsigned CfgWidth     = 16;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned IdWidth      = 7;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned ActionWidth  = 2;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [CfgWidth-1:0] HalfPeriodReset = 16'd300;
  localparam logic [CfgWidth-1:0] StopGapReset    = 16'd500;

  localparam logic [CfgIdxWidth-1:0] CfgHalfPeriod = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgStopGap    = 1'd1;

  localparam logic [ActionWidth-1:0] ActTick  = 2'd0;
  localparam logic [ActionWidth-1:0] ActWrite = 2'd1;
  localparam logic [ActionWidth-1:0] ActRead  = 2'd2;

  typedef struct packed {
    logic                 start;
    logic                 rd;
    logic [IdWidth-1:0]   device_id;
    logic [ByteWidth-1:0] register_address;
    logic [ByteWidth-1:0] write_data;
    logic                 sda_in;
  } item_t;

endpackage

`default_nettype wire

### src/scmc_if.sv
// Handshake channels of the SCCB master controller: tick requests in,
// pin/status results out. Depends on scmc_pkg.
`default_nettype none

interface scmc_in_if;
  logic                            valid;
  logic                            ready;
  logic [scmc_pkg::ActionWidth-1:0] action;
  logic [scmc_pkg::IdWidth-1:0]     device_id;
  logic [scmc_pkg::ByteWidth-1:0]   register_address;
  logic [scmc_pkg::ByteWidth-1:0]   write_data;
  logic                            sda_in;

  modport source (output valid, action, device_id, register_address, write_data, sda_in,
                  input ready);
  modport sink (input valid, action, device_id, register_address, write_data, sda_in,
                output ready);
endinterface

interface scmc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          scl_level;
  logic                          sda_level;
  logic                          sda_drive;
  logic                          busy_res;
  logic                          done_res;
  logic [scmc_pkg::ByteWidth-1:0] read_data;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                read_data, output ready);
endinterface

`default_nettype wire

### src/sccb_master_controller.sv
// SCCB master controller. Each accepted transaction is one bus tick; its
// result is loaded into the output register at the edge that pops it from the
// four-entry queue. One transaction per cycle is sustained while results are
// taken every cycle. rst (synchronous, active high) empties the queue, returns
// the bus engine to idle and restores the timing registers to 300 and 500
// ticks.
`default_nettype none

module sccb_master_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [scmc_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [scmc_pkg::CfgWidth-1:0]    cfg_data,
  scmc_in_if.sink                               req,
  scmc_out_if.source                            rsp
);

  logic [scmc_pkg::CfgWidth-1:0] half_period_ticks;
  logic [scmc_pkg::CfgWidth-1:0] stop_gap_ticks;

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  scmc_pkg::item_t q_in_item;
  scmc_pkg::item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= scmc_pkg::HalfPeriodReset;
      stop_gap_ticks    <= scmc_pkg::StopGapReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scmc_pkg::CfgHalfPeriod: half_period_ticks <= cfg_data;
        scmc_pkg::CfgStopGap:    stop_gap_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  scmc_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in_item)
  );

  scmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  scmc_engine u_engine (
    .clk               (clk),
    .rst               (rst),
    .half_period_ticks (half_period_ticks),
    .stop_gap_ticks    (stop_gap_ticks),
    .q_valid           (q_not_empty),
    .q_item            (q_head),
    .q_pop             (q_pop),
    .rsp               (rsp)
  );

endmodule

`default_nettype wire

### src/scmc_front.sv
// Front end: accepts tick requests and classifies the action code into
// start/read flags for the queue. Depends on scmc_pkg and scmc_if.
`default_nettype none

module scmc_front (
  scmc_in_if.sink        req,
  input  wire logic      q_full,
  output logic           q_push,
  output scmc_pkg::item_t q_item
);

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  // Unused action code three behaves as a plain tick.
  always_comb begin
    q_item.start            = (req.action == scmc_pkg::ActWrite) ||
                              (req.action == scmc_pkg::ActRead);
    q_item.rd               = (req.action == scmc_pkg::ActRead);
    q_item.device_id        = req.device_id;
    q_item.register_address = req.register_address;
    q_item.write_data       = req.write_data;
    q_item.sda_in           = req.sda_in;
  end

endmodule

`default_nettype wire

### src/scmc_queue.sv
// Small FIFO of classified items between the front end and the bus engine.
// Depends on scmc_pkg.
`default_nettype none

module scmc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire scmc_pkg::item_t  push_item,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output scmc_pkg::item_t       head
);

  localparam int unsigned PtrWidth = $clog2(scmc_pkg::QueueDepth);
  localparam int unsigned CntWidth = $clog2(scmc_pkg::QueueDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(scmc_pkg::QueueDepth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(scmc_pkg::QueueDepth);

  scmc_pkg::item_t     entries [scmc_pkg::QueueDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/scmc_engine.sv
// Bus engine: steps the SCCB phase sequencer once per queued tick and
// registers the pin levels and status as one result. Depends on scmc_pkg, scmc_if.
`default_nettype none

module scmc_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [scmc_pkg::CfgWidth-1:0] half_period_ticks,
  input  wire logic [scmc_pkg::CfgWidth-1:0] stop_gap_ticks,
  input  wire logic                          q_valid,
  input  wire scmc_pkg::item_t               q_item,
  output logic                               q_pop,
  scmc_out_if.source                         rsp
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhStartHi  = 4'd1;
  localparam logic [3:0] PhStartLo  = 4'd2;
  localparam logic [3:0] PhTxLow    = 4'd3;
  localparam logic [3:0] PhTxHigh   = 4'd4;
  localparam logic [3:0] PhRestart  = 4'd5;
  localparam logic [3:0] PhRxLow    = 4'd6;
  localparam logic [3:0] PhRxHigh   = 4'd7;
  localparam logic [3:0] PhStopLow  = 4'd8;
  localparam logic [3:0] PhStopHigh = 4'd9;
  localparam logic [3:0] PhStopRise = 4'd10;
  localparam logic [3:0] PhGap      = 4'd11;

  localparam int unsigned CW = scmc_pkg::CfgWidth;
  localparam int unsigned BW = scmc_pkg::ByteWidth;

  logic [3:0]                      phase, phase_next;
  logic [3:0]                      bit_index, bit_index_next;
  logic [CW-1:0]                   tick_count, tick_count_next;
  logic [2:0]                      byte_index, byte_index_next;
  logic                            is_read, is_read_next;
  logic [BW-1:0]                   tx_shift, tx_shift_next;
  logic [BW-1:0]                   rx_shift, rx_shift_next;
  logic [scmc_pkg::IdWidth-1:0]    held_id, held_id_next;
  logic [BW-1:0]                   held_address, held_address_next;
  logic [BW-1:0]                   held_data, held_data_next;

  logic [CW-1:0] dur;
  logic [CW:0]   tick_inc;
  logic          expire;
  logic          done_next;
  logic          txbit;
  logic          scl_next, lvl_next, drv_next;

  function automatic logic [BW-1:0] byte_for(input logic [2:0] idx, input logic rd,
                                             input logic [scmc_pkg::IdWidth-1:0] id,
                                             input logic [BW-1:0] addr,
                                             input logic [BW-1:0] data);
    logic [BW-1:0] r;
    if (idx == 3'd0) begin
      r = {id, 1'b0};
    end else if (idx == 3'd1) begin
      r = addr;
    end else if (rd) begin
      r = {id, 1'b1};
    end else begin
      r = data;
    end
    return r;
  endfunction

  // The result slot frees when it is empty or being taken this cycle.
  assign q_pop = q_valid && (!rsp.valid || rsp.ready);

  always_comb begin
    if (phase == PhGap) begin
      dur = stop_gap_ticks;
    end else if (half_period_ticks == '0) begin
      dur = CW'(1);
    end else begin
      dur = half_period_ticks;
    end
    tick_inc = {1'b0, tick_count} + 1'b1;
    expire   = (tick_inc >= {1'b0, dur});
  end

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    tick_count_next   = tick_count;
    byte_index_next   = byte_index;
    is_read_next      = is_read;
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    held_id_next      = held_id;
    held_address_next = held_address;
    held_data_next    = held_data;
    done_next         = 1'b0;

    if (phase == PhIdle) begin
      if (q_item.start) begin
        held_id_next      = q_item.device_id;
        held_address_next = q_item.register_address;
        held_data_next    = q_item.write_data;
        is_read_next      = q_item.rd;
        if (q_item.rd) begin
          rx_shift_next = '0;
        end
        byte_index_next = '0;
        bit_index_next  = '0;
        tick_count_next = '0;
        phase_next      = PhStartHi;
      end
    end else begin
      // Read bits are sampled on the first tick of the first eight high halves.
      if (phase == PhRxHigh && tick_count == '0 && bit_index < 4'd8) begin
        rx_shift_next = {rx_shift[BW-2:0], q_item.sda_in};
      end
      tick_count_next = tick_inc[CW-1:0];
      if (expire) begin
        tick_count_next = '0;
        unique case (phase)
          PhStartHi: phase_next = PhStartLo;
          PhStartLo: begin
            tx_shift_next  = byte_for(byte_index, is_read, held_id, held_address,
                                      held_data);
            bit_index_next = '0;
            phase_next     = PhTxLow;
          end
          PhTxLow: phase_next = PhTxHigh;
          PhTxHigh: begin
            if (bit_index < 4'd8) begin
              tx_shift_next = {tx_shift[BW-2:0], 1'b0};
            end
            bit_index_next = bit_index + 1'b1;
            if (bit_index_next < 4'd9) begin
              phase_next = PhTxLow;
            end else if (!is_read && byte_index < 3'd2) begin
              byte_index_next = byte_index + 1'b1;
              tx_shift_next   = byte_for(byte_index_next, is_read, held_id,
                                         held_address, held_data);
              bit_index_next  = '0;
              phase_next      = PhTxLow;
            end else if (!is_read) begin
              phase_next = PhStopLow;
            end else if (byte_index == 3'd0) begin
              byte_index_next = 3'd1;
              tx_shift_next   = byte_for(3'd1, is_read, held_id, held_address,
                                         held_data);
              bit_index_next  = '0;
              phase_next      = PhTxLow;
            end else if (byte_index == 3'd1) begin
              byte_index_next = 3'd2;
              phase_next      = PhRestart;
            end else begin
              bit_index_next = '0;
              phase_next     = PhRxLow;
            end
          end
          PhRestart: phase_next = PhStartHi;
          PhRxLow:   phase_next = PhRxHigh;
          PhRxHigh: begin
            bit_index_next = bit_index + 1'b1;
            phase_next     = (bit_index_next < 4'd9) ? PhRxLow : PhStopLow;
          end
          PhStopLow:  phase_next = PhStopHigh;
          PhStopHigh: phase_next = PhStopRise;
          PhStopRise: begin
            if (stop_gap_ticks == '0) begin
              phase_next = PhIdle;
              done_next  = 1'b1;
            end else begin
              phase_next = PhGap;
            end
          end
          default: begin
            phase_next = PhIdle;
            done_next  = 1'b1;
          end
        endcase
      end
    end

    txbit = (bit_index_next < 4'd8) ? tx_shift_next[BW-1] : 1'b0;
    unique case (phase_next)
      PhStartLo:  begin scl_next = 1'b1; lvl_next = 1'b0;  drv_next = 1'b1; end
      PhTxLow:    begin scl_next = 1'b0; lvl_next = txbit; drv_next = 1'b1; end
      PhTxHigh:   begin scl_next = 1'b1; lvl_next = txbit; drv_next = 1'b1; end
      PhRestart:  begin scl_next = 1'b0; lvl_next = 1'b1;  drv_next = 1'b1; end
      PhRxLow:    begin scl_next = 1'b0; lvl_next = 1'b0;  drv_next = 1'b0; end
      PhRxHigh:   begin scl_next = 1'b1; lvl_next = 1'b0;  drv_next = 1'b0; end
      PhStopLow:  begin scl_next = 1'b0; lvl_next = 1'b0;  drv_next = 1'b1; end
      PhStopHigh: begin scl_next = 1'b1; lvl_next = 1'b0;  drv_next = 1'b1; end
      default:    begin scl_next = 1'b1; lvl_next = 1'b1;  drv_next = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhIdle;
      bit_index    <= '0;
      tick_count   <= '0;
      byte_index   <= '0;
      is_read      <= 1'b0;
      tx_shift     <= '0;
      rx_shift     <= '0;
      held_id      <= '0;
      held_address <= '0;
      held_data    <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        bit_index    <= bit_index_next;
        tick_count   <= tick_count_next;
        byte_index   <= byte_index_next;
        is_read      <= is_read_next;
        tx_shift     <= tx_shift_next;
        rx_shift     <= rx_shift_next;
        held_id      <= held_id_next;
        held_address <= held_address_next;
        held_data    <= held_data_next;
        rsp.valid    <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp.scl_level <= scl_next;
      rsp.sda_level <= lvl_next;
      rsp.sda_drive <= drv_next;
      rsp.busy_res  <= (phase_next != PhIdle);
      rsp.done_res  <= done_next;
      rsp.read_data <= rx_shift_next;
    end
  end

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PhIdle) |-> (tick_count == '0))
    else $error("tick counter not cleared in idle");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    (bit_index <= 4'd9))
    else $error("bit index out of range");

  a_read_phases: assert property (@(posedge clk) disable iff (rst)
    (phase == PhRxLow || phase == PhRxHigh || phase == PhRestart) |-> is_read)
    else $error("read phase reached in a write transaction");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.done_res) |-> (!rsp.busy_res && phase == PhIdle))
    else $error("done reported while still busy");

  a_pop_makes_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> rsp.valid)
    else $error("queued tick produced no result");

endmodule

`default_nettype wire
